// ----- sv/mbss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scanner package
// Shared widths, register indexes and the signature byte pick function.
// ----------------------------------------------------------------------------
package mbss_pkg;

    localparam int MBSS_MAX_SIG_LEN = 16;
    localparam int MBSS_POS_BITS    = 24;

    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int SIG_BITS   = 128;
    localparam int LEN_REG_W  = 5;
    localparam int DELTA_W    = 16;
    localparam int LOC_W      = 26;
    localparam int PICK_W     = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALUE_LO = 3'd0,
        CFG_VALUE_HI = 3'd1,
        CFG_MASK_LO  = 3'd2,
        CFG_MASK_HI  = 3'd3,
        CFG_LENGTH   = 3'd4,
        CFG_DELTA    = 3'd5
    } cfg_idx_t;

    // bytes 16 and up read as zero
    function automatic logic [7:0] sig_pick(input logic [SIG_BITS-1:0] bytes,
                                            input logic [PICK_W-1:0] j);
        logic [7:0] r;
        r = '0;
        if (j < PICK_W'(16))
            r = bytes[{j[3:0], 3'b000} +: 8];
        return r;
    endfunction

endpackage

// ----- sv/mbss_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signature window compare
// Compares each of the first len window bytes, masked, against its aligned signature byte.
// ----------------------------------------------------------------------------
module mbss_match
    import mbss_pkg::*;
#(
    parameter int  MAX_SIG_LEN = MBSS_MAX_SIG_LEN,
    localparam int LEN_W       = $clog2(MAX_SIG_LEN + 1)
)
(
    input  logic [MAX_SIG_LEN-1:0][7:0] window,
    input  logic [SIG_BITS-1:0]         sig_value,
    input  logic [SIG_BITS-1:0]         sig_mask,
    input  logic [LEN_W-1:0]            len,
    output logic                        hit
);

    logic [PICK_W-1:0] j;
    logic [7:0]        m;
    logic [7:0]        v;

    // window byte k pairs with signature byte len-1-k
    always_comb
    begin
        hit = 1'b1;
        j   = '0;
        m   = '0;
        v   = '0;
        for (int k = 0; k < MAX_SIG_LEN; k++)
        begin
            j = PICK_W'(len - LEN_W'(1) - LEN_W'(k));
            m = sig_pick(sig_mask, j);
            v = sig_pick(sig_value, j);
            if ((LEN_W'(k) < len) && ((window[k] & m) != v))
                hit = 1'b0;
        end
    end

endmodule

// ----- sv/masked_byte_signature_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte signature scanner
// Streams bytes through a window and reports the first masked signature hit, or not found on the last byte.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   scan_byte, is_last
// out      output     out_valid/out_ready found, location
// cfg      input      cfg_wr_en           cfg_index, cfg_wdata
//
// One byte per cycle unless a held result stalls input; a byte is registered,
// then compared against the first len window positions in parallel in the
// next cycle, and its result is registered when the stage fires.
// Reset clears scan state and loads register defaults.
// A held result stalls input only when the next byte also produces a result.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner_unit
    import mbss_pkg::*;
#(
    parameter int MAX_SIG_LEN = MBSS_MAX_SIG_LEN,
    parameter int POS_BITS    = MBSS_POS_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              scan_byte,
    input  logic                    is_last,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    found,
    output logic signed [LOC_W-1:0] location
);

    localparam int LEN_W  = $clog2(MAX_SIG_LEN + 1);
    localparam int LC_W   = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
    localparam int SUM_W  = ((POS_BITS > LOC_W) ? POS_BITS : LOC_W) + 1;

    logic [CFG_W-1:0]           value_lo_reg;
    logic [CFG_W-1:0]           value_hi_reg;
    logic [CFG_W-1:0]           mask_lo_reg;
    logic [CFG_W-1:0]           mask_hi_reg;
    logic [LEN_REG_W-1:0]       length_reg;
    logic signed [DELTA_W-1:0]  delta_reg;

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_last_reg;

    logic [MAX_SIG_LEN-1:0][7:0] win_reg;
    logic [MAX_SIG_LEN-1:0][7:0] win_next;
    logic [POS_BITS-1:0]        pos_reg;
    logic                       found_reg;

    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic [LOC_W-1:0]           out_loc_reg;
    logic                       out_valid_next;

    logic [LC_W-1:0]            len_ext;
    logic [LC_W-1:0]            len_clamp;
    logic [LEN_W-1:0]           len_eff;
    logic                       window_hit;
    logic                       pos_ok;
    logic                       match;
    logic                       res;
    logic                       s1_fire;
    logic [SUM_W-1:0]           start_pos;
    logic [SUM_W-1:0]           loc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_lo_reg <= '0;
            value_hi_reg <= '0;
            mask_lo_reg  <= '0;
            mask_hi_reg  <= '0;
            length_reg   <= LEN_REG_W'(1);
            delta_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_VALUE_LO: value_lo_reg <= cfg_wdata;
                CFG_VALUE_HI: value_hi_reg <= cfg_wdata;
                CFG_MASK_LO:  mask_lo_reg  <= cfg_wdata;
                CFG_MASK_HI:  mask_hi_reg  <= cfg_wdata;
                CFG_LENGTH:   length_reg   <= cfg_wdata[LEN_REG_W-1:0];
                CFG_DELTA:    delta_reg    <= cfg_wdata[DELTA_W-1:0];
                default:      ;
            endcase
        end
    end

    // clamp length into 1..MAX_SIG_LEN
    always_comb
    begin
        len_ext = LC_W'(length_reg);
        if (len_ext == '0)
            len_clamp = LC_W'(1);
        else if (len_ext > LC_W'(MAX_SIG_LEN))
            len_clamp = LC_W'(MAX_SIG_LEN);
        else
            len_clamp = len_ext;
        len_eff = len_clamp[LEN_W-1:0];
    end

    always_comb
    begin
        win_next[0] = s1_byte_reg;
        for (int k = 1; k < MAX_SIG_LEN; k++)
            win_next[k] = win_reg[k-1];
    end

    mbss_match #(
        .MAX_SIG_LEN (MAX_SIG_LEN)
    ) u_match (
        .window    (win_next),
        .sig_value ({value_hi_reg, value_lo_reg}),
        .sig_mask  ({mask_hi_reg, mask_lo_reg}),
        .len       (len_eff),
        .hit       (window_hit)
    );

    assign start_pos = SUM_W'(pos_reg) + SUM_W'(1) - SUM_W'(len_eff);
    assign pos_ok    = (pos_reg != '1) &&
                       ((SUM_W'(pos_reg) + SUM_W'(1)) >= SUM_W'(len_eff));
    assign match     = pos_ok && window_hit;
    assign loc_sum   = start_pos + SUM_W'(delta_reg);
    assign res       = s1_valid_reg && !found_reg && (match || s1_last_reg);
    assign s1_fire   = s1_valid_reg && (!res || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= scan_byte;
            s1_last_reg <= is_last;
        end
    end

    // window holds payload only; matches never look past the scanned bytes
    always_ff @(posedge clk)
    begin
        if (s1_fire && !found_reg)
            win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (!found_reg)
            begin
                if (pos_reg != '1)
                    pos_reg <= pos_reg + POS_BITS'(1);
                found_reg <= match;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_fire && res)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res)
        begin
            out_found_reg <= match;
            out_loc_reg   <= match ? loc_sum[LOC_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign location  = out_loc_reg;

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> location == '0)
        else $error("not-found result carries nonzero location");

    a_found_holds: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && !(s1_fire && s1_last_reg) |=> found_reg)
        else $error("match flag dropped before last byte");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> pos_reg == '0 && !found_reg)
        else $error("scan state not cleared after last byte");

    a_no_result_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && found_reg |=> !(out_valid && !$past(out_valid_reg && !out_ready)))
        else $error("result produced after a match in the same scan");

endmodule
